// ===== sv/iadpcm_pkg.sv =====
// ----------------------------------------------------------------------------
// iadpcm_pkg
// shared types, constants and table functions of the ima adpcm state decoder
// ----------------------------------------------------------------------------
package iadpcm_pkg;

    localparam int unsigned IDX_W  = 7;
    localparam int unsigned STEP_W = 15;
    localparam int unsigned DIFF_W = 17;

    localparam logic [IDX_W-1:0] MAX_INDEX = 7'd88;

    localparam logic signed [15:0] PRED_MAX = 16'sh7fff;
    localparam logic signed [15:0] PRED_MIN = -16'sh8000;

    // phase bit of the state word
    localparam logic PHASE_HIGH = 1'b1;
    localparam logic PHASE_LOW  = 1'b0;

    localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
        15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
        15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
        15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
        15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
        15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
        15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
        15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
        15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
        15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
        15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
        15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
        15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
        15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    // clamp an index to the top of the step table
    function automatic logic [IDX_W-1:0] sat_index(input logic [IDX_W-1:0] idx);
        return (idx > MAX_INDEX) ? MAX_INDEX : idx;
    endfunction

    function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
        return STEP_TABLE[sat_index(idx)];
    endfunction

    // index movement per code, sign bit ignored
    function automatic logic signed [4:0] index_adj(input logic [3:0] code);
        logic signed [4:0] adj;
        unique case (code[2:0])
            3'd4:    adj = 5'sd2;
            3'd5:    adj = 5'sd4;
            3'd6:    adj = 5'sd6;
            3'd7:    adj = 5'sd8;
            default: adj = -5'sd1;
        endcase
        return adj;
    endfunction

endpackage

// ===== sv/iadpcm_in_if.sv =====
// ----------------------------------------------------------------------------
// iadpcm_in_if
// code byte channel of the ima adpcm state decoder
// ----------------------------------------------------------------------------
interface iadpcm_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         code_byte;
    logic               both_nibbles;
    logic               block_start;
    logic signed [15:0] start_predictor;
    logic [6:0]         start_index;
    logic               final_byte;

    modport source (
        output valid, code_byte, both_nibbles, block_start, start_predictor,
               start_index, final_byte,
        input  ready
    );
    modport sink (
        input  valid, code_byte, both_nibbles, block_start, start_predictor,
               start_index, final_byte,
        output ready
    );
endinterface

// ===== sv/iadpcm_out_if.sv =====
// ----------------------------------------------------------------------------
// iadpcm_out_if
// decoded sample channel of the ima adpcm state decoder
// ----------------------------------------------------------------------------
interface iadpcm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [31:0]        state_word;
    logic               last;

    modport source (
        output valid, sample, state_word, last,
        input  ready
    );
    modport sink (
        input  valid, sample, state_word, last,
        output ready
    );
endinterface

// ===== sv/ima_adpcm_state_decoder.sv =====
// ----------------------------------------------------------------------------
// ima_adpcm_state_decoder
// 4-bit ima adpcm decoder, one code byte in, one or two samples out
// ----------------------------------------------------------------------------
// Each transfer on i_in carries one code byte. The high nibble is decoded
// first, then the low nibble when both_nibbles is set, each giving one
// transfer on o_out with the saturated predictor, a packed state word
// ({phase, step index, code byte, predictor}) and a last flag that follows
// final_byte on the byte's final sample. block_start loads start_predictor
// and start_index (clamped to 88) ahead of the high nibble. A byte decoding
// both nibbles holds the input register until both have moved into the
// result register, which takes one sample per cycle while it is free; a
// single-nibble byte leaves after its one nibble. The input register accepts
// the next byte in the same cycle its last nibble moves into the result
// register, and the result register refills while its current sample is
// taken, so with both sides open the block runs at one sample per cycle
// without bubbles.
// ----------------------------------------------------------------------------
module ima_adpcm_state_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    iadpcm_in_if.sink    i_in,
    iadpcm_out_if.source o_out
);

    // input register, held until its last nibble is decoded
    logic               r_in_valid;
    logic               r_low;          // low nibble pending
    logic [7:0]         r_byte;
    logic               r_both;
    logic               r_start;
    logic signed [15:0] r_start_pred;
    logic [6:0]         r_start_idx;
    logic               r_final;

    // decoder state
    logic signed [15:0] r_pred;
    logic [6:0]         r_idx;

    // result register
    logic               r_out_valid;
    logic signed [15:0] r_sample;
    logic [31:0]        r_state_word;
    logic               r_last;

    logic               out_free;
    logic               fire;
    logic               done;
    logic               in_take;

    logic               load_start;
    logic signed [15:0] base_pred;
    logic [6:0]         base_idx;
    logic [3:0]         nib;
    logic [iadpcm_pkg::STEP_W-1:0] step;
    logic [iadpcm_pkg::DIFF_W-1:0] diff;
    logic signed [17:0] sum;
    logic signed [8:0]  idx_sum;
    logic signed [15:0] n_pred;
    logic [6:0]         n_idx;
    logic               n_last;
    logic               phase;

    // handshake
    assign out_free = !r_out_valid || o_out.ready;
    assign fire     = r_in_valid && out_free;
    assign done     = fire && (r_low || !r_both);
    assign i_in.ready = !r_in_valid || done;
    assign in_take  = i_in.valid && i_in.ready;

    // nibble decode
    always_comb begin
        load_start = !r_low && r_start;
        base_pred  = load_start ? r_start_pred : r_pred;
        base_idx   = load_start ? iadpcm_pkg::sat_index(r_start_idx) : r_idx;
        nib        = r_low ? r_byte[3:0] : r_byte[7:4];
        step       = iadpcm_pkg::step_size(base_idx);

        // (magnitude + 0.5) * step / 4 with truncating shifts
        diff = {2'b00, step >> 3};
        if (nib[2]) begin
            diff = diff + {2'b00, step};
        end
        if (nib[1]) begin
            diff = diff + {2'b00, step >> 1};
        end
        if (nib[0]) begin
            diff = diff + {2'b00, step >> 2};
        end

        if (nib[3]) begin
            sum = {{2{base_pred[15]}}, base_pred} - $signed({1'b0, diff});
        end else begin
            sum = {{2{base_pred[15]}}, base_pred} + $signed({1'b0, diff});
        end

        // saturate to the 16-bit signed range
        if (sum > 18'(iadpcm_pkg::PRED_MAX)) begin
            n_pred = iadpcm_pkg::PRED_MAX;
        end else if (sum < 18'(iadpcm_pkg::PRED_MIN)) begin
            n_pred = iadpcm_pkg::PRED_MIN;
        end else begin
            n_pred = sum[15:0];
        end

        // index step with clamp to 0..88
        idx_sum = $signed({2'b00, base_idx}) + 9'(iadpcm_pkg::index_adj(nib));
        if (idx_sum < 9'sd0) begin
            n_idx = '0;
        end else if (idx_sum > $signed({2'b00, iadpcm_pkg::MAX_INDEX})) begin
            n_idx = iadpcm_pkg::MAX_INDEX;
        end else begin
            n_idx = idx_sum[6:0];
        end

        phase  = r_low ? iadpcm_pkg::PHASE_LOW : iadpcm_pkg::PHASE_HIGH;
        n_last = (r_low || !r_both) && r_final;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_low       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pred      <= '0;
            r_idx       <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
                r_low      <= 1'b0;
            end else if (done) begin
                r_in_valid <= 1'b0;
                r_low      <= 1'b0;
            end else if (fire) begin
                // high nibble out, low nibble next
                r_low <= 1'b1;
            end

            if (fire) begin
                r_out_valid <= 1'b1;
                r_pred      <= n_pred;
                r_idx       <= n_idx;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte       <= i_in.code_byte;
            r_both       <= i_in.both_nibbles;
            r_start      <= i_in.block_start;
            r_start_pred <= i_in.start_predictor;
            r_start_idx  <= i_in.start_index;
            r_final      <= i_in.final_byte;
        end
        if (fire) begin
            r_sample     <= n_pred;
            r_state_word <= {phase, n_idx, r_byte, n_pred};
            r_last       <= n_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample     = r_sample;
    assign o_out.state_word = r_state_word;
    assign o_out.last       = r_last;

endmodule
